### rtl/core/ssum_pkg.sv
package ssum_pkg;

    // element width and default store depth
    localparam int DATA_W      = 32;
    localparam int MAX_LEN_DEF = 256;

    // one input beat
    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     is_last;
    } in_t;

    // one result beat
    typedef struct packed {
        logic found;
        logic too_long;
    } out_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;   // accepted input beat
        logic scan;   // issue one store read of the search
        logic clear;  // end of sequence, reset count and overflow
    } cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic last_issue;  // read being issued is the final one of the search
    } sts_t;

endpackage

### rtl/core/subarray_sum_search.sv
// Contiguous-run sum search.
// Input channel: an item beat (value, is_last) is taken at a rising edge with
// start high and busy low. Items are stored in order, one per cycle while
// busy is low; items beyond MAX_LEN are dropped and flagged as too_long.
// Configuration: cfg_we writes cfg_data into the target register at the edge;
// write it only while the block is idle.
// Result channel: after the beat with is_last set, busy rises and the block
// searches every start position and every run from there, one store read and
// one accumulate per cycle, through the single read port of the element store.
// The result (found, too_long) sits on result for one cycle with done high;
// the receiver cannot stall it. busy drops in the next cycle and a new
// sequence may start. The target register is kept between sequences.
// Reset clears the element count, the overflow flag, the target and all
// control state; the element store itself is not cleared.
module subarray_sum_search #(
    parameter int MAX_LEN = ssum_pkg::MAX_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  ssum_pkg::in_t                       item,
    input  logic                                cfg_we,
    input  logic signed [ssum_pkg::DATA_W-1:0]  cfg_data,
    output logic                                done,
    output ssum_pkg::out_t                      result
);

    ssum_pkg::cmd_t cmd;
    ssum_pkg::sts_t sts;

    // sequencing
    ssum_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .is_last (item.is_last),
        .sts     (sts),
        .busy    (busy),
        .done    (done),
        .cmd     (cmd)
    );

    // store, run walk and accumulator
    ssum_dp #(
        .MAX_LEN (MAX_LEN)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .result   (result)
    );

endmodule

### rtl/core/ssum_ctrl.sv
module ssum_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              is_last,
    input  ssum_pkg::sts_t    sts,
    output logic              busy,
    output logic              done,
    output ssum_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_LOAD   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_REPORT = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (start && is_last)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.last_issue)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_REPORT;
            end
            ST_REPORT:
            begin
                state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // handshake and commands
    assign busy      = (state_reg != ST_LOAD);
    assign done      = (state_reg == ST_REPORT);
    assign cmd.load  = start && (state_reg == ST_LOAD);
    assign cmd.scan  = (state_reg == ST_SCAN);
    assign cmd.clear = (state_reg == ST_REPORT);

    // result strobe lasts one cycle
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for more than one cycle");

    // the closing beat always starts a search
    a_last_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && is_last) |=> (busy && cmd.scan))
        else $error("closing beat did not start the search");

    // a result returns the block to loading
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy)
        else $error("block still busy after the result");

endmodule

### rtl/core/ssum_dp.sv
module ssum_dp #(
    parameter int MAX_LEN = ssum_pkg::MAX_LEN_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ssum_pkg::in_t                       item,
    input  logic                                cfg_we,
    input  logic signed [ssum_pkg::DATA_W-1:0]  cfg_data,
    input  ssum_pkg::cmd_t                      cmd,
    output ssum_pkg::sts_t                      sts,
    output ssum_pkg::out_t                      result
);

    localparam int DW     = ssum_pkg::DATA_W;
    localparam int ADDR_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int ACC_W  = DW + ADDR_W + 1;

    // element store
    logic [DW-1:0]      store_reg [MAX_LEN];
    logic [DW-1:0]      rdata_reg;

    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               ovf_reg;
    logic               ovf_next;
    logic [ADDR_W-1:0]  start_reg;
    logic [ADDR_W-1:0]  start_next;
    logic [ADDR_W-1:0]  idx_reg;
    logic [ADDR_W-1:0]  idx_next;
    logic               rd_vld_reg;
    logic               rd_vld_next;
    logic               rd_first_reg;
    logic               rd_first_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic               found_reg;
    logic               found_next;
    logic signed [DW-1:0] target_reg;

    logic               room;
    logic [CNT_W-1:0]   count_m1;
    logic [ADDR_W-1:0]  last_idx;
    logic signed [ACC_W-1:0] elem_ext;
    logic signed [ACC_W-1:0] goal_ext;
    logic signed [ACC_W-1:0] acc_base;

    assign room     = (count_reg < CNT_W'(MAX_LEN));
    assign count_m1 = count_reg - CNT_W'(1);
    assign last_idx = count_m1[ADDR_W-1:0];
    assign elem_ext = {{(ACC_W-DW){rdata_reg[DW-1]}}, rdata_reg};
    assign goal_ext = {{(ACC_W-DW){target_reg[DW-1]}}, target_reg};
    assign acc_base = rd_first_reg ? '0 : acc_reg;

    assign sts.last_issue = cmd.scan && (start_reg == last_idx) && (idx_reg == last_idx);

    assign result.found    = found_reg;
    assign result.too_long = ovf_reg;

    // store write on load, registered read on scan
    always_ff @(posedge clk)
    begin
        if (cmd.load && room)
        begin
            store_reg[count_reg[ADDR_W-1:0]] <= item.value;
        end
        if (cmd.scan)
        begin
            rdata_reg <= store_reg[idx_reg];
        end
    end

    // sequence bookkeeping, run indices and running sum
    always_comb
    begin
        count_next    = count_reg;
        ovf_next      = ovf_reg;
        start_next    = start_reg;
        idx_next      = idx_reg;
        rd_vld_next   = cmd.scan;
        rd_first_next = rd_first_reg;
        acc_next      = acc_reg;
        found_next    = found_reg;

        if (cmd.load)
        begin
            if (room)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
            if (item.is_last)
            begin
                start_next = '0;
                idx_next   = '0;
                found_next = 1'b0;
            end
        end

        // walk runs: idx to the end, then next start
        if (cmd.scan)
        begin
            rd_first_next = (idx_reg == start_reg);
            if (idx_reg == last_idx)
            begin
                start_next = start_reg + ADDR_W'(1);
                idx_next   = start_reg + ADDR_W'(1);
            end
            else
            begin
                idx_next = idx_reg + ADDR_W'(1);
            end
        end

        // accumulate the element read last cycle and compare
        if (rd_vld_reg)
        begin
            acc_next = acc_base + elem_ext;
            if (acc_next == goal_ext)
            begin
                found_next = 1'b1;
            end
        end

        if (cmd.clear)
        begin
            count_next = '0;
            ovf_next   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            start_reg    <= '0;
            idx_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            acc_reg      <= '0;
            found_reg    <= 1'b0;
            target_reg   <= '0;
        end
        else
        begin
            count_reg    <= count_next;
            ovf_reg      <= ovf_next;
            start_reg    <= start_next;
            idx_reg      <= idx_next;
            rd_vld_reg   <= rd_vld_next;
            rd_first_reg <= rd_first_next;
            acc_reg      <= acc_next;
            found_reg    <= found_next;
            if (cfg_we)
            begin
                target_reg <= cfg_data;
            end
        end
    end

    // count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_LEN))
        else $error("element count beyond store depth");

    // overflow only with a full store
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CNT_W'(MAX_LEN)))
        else $error("overflow flagged with room left");

    // read data is only used in the cycle after a scan read
    a_rd_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |=> rd_vld_reg)
        else $error("scan read not followed by accumulate");

endmodule

### tb/testbench.sv
module testbench;

    localparam int DEPTH   = ssum_pkg::MAX_LEN_DEF;
    localparam int ITEMS   = 1000;
    localparam int LIMIT   = 3000000;

    // predicts the answer of each closed sequence and checks result beats
    class sum_hit_board;
        logic signed [ssum_pkg::DATA_W-1:0] elems [ssum_pkg::MAX_LEN_DEF];
        int unsigned                        stored;
        bit                                 dropped;
        logic signed [ssum_pkg::DATA_W-1:0] goal;
        ssum_pkg::out_t                     pending_answers [$];
        int                                 mismatches;
        int                                 answers_checked;
        int                                 hits_seen;
        int                                 overflows_seen;

        function new();
            stored          = 0;
            dropped         = 1'b0;
            goal            = '0;
            mismatches      = 0;
            answers_checked = 0;
            hits_seen       = 0;
            overflows_seen  = 0;
        endfunction

        task report_mismatch(input string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        // exact 64-bit search over every start and every run from it
        function bit run_sum_hits();
            longint acc;
            longint want;
            want = longint'(goal);
            for (int s = 0; s < stored; s++)
            begin
                acc = 0;
                for (int i = s; i < stored; i++)
                begin
                    acc += longint'(elems[i]);
                    if (acc == want)
                        return 1'b1;
                end
            end
            return 1'b0;
        endfunction

        function void note_element(input ssum_pkg::in_t beat);
            ssum_pkg::out_t ans;
            if (stored < ssum_pkg::MAX_LEN_DEF)
            begin
                elems[stored] = beat.value;
                stored++;
            end
            else
                dropped = 1'b1;
            if (beat.is_last)
            begin
                ans.found    = run_sum_hits();
                ans.too_long = dropped;
                pending_answers.push_back(ans);
                stored  = 0;
                dropped = 1'b0;
            end
        endfunction

        task check_answer(input ssum_pkg::out_t got);
            ssum_pkg::out_t want;
            if (pending_answers.size() == 0)
            begin
                report_mismatch($sformatf("result with none pending: found=%b too_long=%b",
                                          got.found, got.too_long));
                return;
            end
            want = pending_answers.pop_front();
            if (got.found !== want.found)
                report_mismatch($sformatf("answer %0d: found=%b, predicted %b",
                                          answers_checked, got.found, want.found));
            if (got.too_long !== want.too_long)
                report_mismatch($sformatf("answer %0d: too_long=%b, predicted %b",
                                          answers_checked, got.too_long, want.too_long));
            answers_checked++;
            if (want.found)
                hits_seen++;
            if (want.too_long)
                overflows_seen++;
        endtask
    endclass

    logic                               clk;
    logic                               rst_n;
    logic                               start;
    logic                               busy;
    ssum_pkg::in_t                      item;
    logic                               cfg_we;
    logic signed [ssum_pkg::DATA_W-1:0] cfg_data;
    logic                               done;
    ssum_pkg::out_t                     result;

    sum_hit_board                       sb;
    logic signed [ssum_pkg::DATA_W-1:0] seq_vals [$];
    bit                                 idle_on;
    int                                 items_sent;
    int                                 seqs_sent;
    int                                 targets_written;
    int                                 cycles = 0;

    subarray_sum_search #(
        .MAX_LEN (DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("subarray_sum_search test failed");
            $finish;
        end
    end

    // result beats cannot be held off, take each one as it comes
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && done === 1'b1)
            sb.check_answer(result);
    end

    // random idle gap, with start low, before some beats while idle_on is set
    task idle_burst();
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task send_beat(input logic signed [ssum_pkg::DATA_W-1:0] v, input bit last);
        ssum_pkg::in_t beat;
        beat.value   = v;
        beat.is_last = last;
        idle_burst();
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        sb.note_element(beat);
        items_sent++;
    endtask

    // wait until every answer is in and the block is idle again
    task drain();
        start <= 1'b0;
        while (sb.pending_answers.size() != 0)
            @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    task write_target(input logic signed [ssum_pkg::DATA_W-1:0] t);
        cfg_data <= t;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.goal = t;
        targets_written++;
    endtask

    task play(input bit retarget, input logic signed [ssum_pkg::DATA_W-1:0] tgt);
        if (retarget)
        begin
            drain();
            write_target(tgt);
        end
        for (int k = 0; k < seq_vals.size(); k++)
            send_beat(seq_vals[k], k == seq_vals.size() - 1);
        seqs_sent++;
    endtask

    function automatic logic signed [ssum_pkg::DATA_W-1:0] rand_element(input int mode);
        case (mode)
            0: return ssum_pkg::DATA_W'(int'($urandom_range(0, 20)) - 10);
            1: return $urandom;
            default:
                case ($urandom_range(0, 5))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    3: return 32'sd1;
                    4: return -32'sd1;
                    default: return $urandom;
                endcase
        endcase
    endfunction

    // target planted on a stored run, or small, or arbitrary, or an extreme
    function automatic logic signed [ssum_pkg::DATA_W-1:0] pick_target(input int mode);
        int     n;
        int     lo;
        int     hi;
        longint psum;
        case (mode)
            0:
            begin
                n  = (seq_vals.size() < DEPTH) ? seq_vals.size() : DEPTH;
                lo = $urandom_range(0, n - 1);
                hi = $urandom_range(lo, n - 1);
                psum = 0;
                for (int i = lo; i <= hi; i++)
                    psum += longint'(seq_vals[i]);
                if (psum >= -64'sd2147483648 && psum <= 64'sd2147483647)
                    return psum[ssum_pkg::DATA_W-1:0];
                return $urandom;
            end
            1: return ssum_pkg::DATA_W'(int'($urandom_range(0, 40)) - 20);
            2: return $urandom;
            default:
                case ($urandom_range(0, 3))
                    0: return 32'sh7FFFFFFF;
                    1: return 32'sh80000000;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
        endcase
    endfunction

    initial
    begin
        int len;
        int vmode;
        int rand_seqs;
        sb = new();
        rst_n    <= 1'b0;
        start    <= 1'b0;
        item     <= '0;
        cfg_we   <= 1'b0;
        cfg_data <= '0;
        idle_on         = 1'b0;
        items_sent      = 0;
        seqs_sent       = 0;
        targets_written = 0;
        rand_seqs       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset target, extremes, no-wrap sums, hits and misses
        seq_vals = '{32'sd1, -32'sd1};
        play(1'b0, '0);
        seq_vals = '{32'sh7FFFFFFF};
        play(1'b1, 32'sh7FFFFFFF);
        seq_vals = '{32'sh80000000};
        play(1'b1, 32'sh80000000);
        // a 32-bit accumulator would wrap to zero here
        seq_vals = '{32'sh80000000, 32'sh80000000};
        play(1'b1, 32'sd0);
        seq_vals = '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sd2};
        play(1'b0, '0);
        // positive run past the top must not alias to the bottom
        seq_vals = '{32'sh7FFFFFFF, 32'sd1};
        play(1'b1, 32'sh80000000);
        seq_vals = '{32'sd3, -32'sd7, 32'sd4, 32'sd9};
        play(1'b1, 32'sd6);
        seq_vals = '{32'sd1, 32'sd2, 32'sd3};
        play(1'b1, 32'sd4);
        seq_vals = '{-32'sd5};
        play(1'b1, -32'sd5);

        // random sequences, a few filling and overflowing the store
        while (items_sent < ITEMS)
        begin
            if (items_sent >= ITEMS * 85 / 100)
                idle_on = 1'b0;
            else
                idle_on = ($urandom_range(0, 3) != 0);
            case (rand_seqs)
                4:  len = DEPTH;
                15: len = DEPTH + 1;
                30: len = DEPTH + 2 + $urandom_range(0, 40);
                default:
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
                                                      : $urandom_range(1, 16);
            endcase
            vmode = $urandom_range(0, 2);
            seq_vals.delete();
            for (int k = 0; k < len; k++)
                seq_vals.push_back(rand_element(vmode));
            play($urandom_range(0, 3) != 0, pick_target($urandom_range(0, 3)));
            rand_seqs++;
        end

        drain();
        repeat (8) @(posedge clk);
        $display("ran %0d sequences of %0d elements under %0d target settings",
                 seqs_sent, items_sent, targets_written);
        $display("checked %0d answers: %0d with a matching run, %0d with dropped elements",
                 sb.answers_checked, sb.hits_seen, sb.overflows_seen);
        if (sb.mismatches == 0)
            $display("subarray_sum_search test passed");
        else
            $display("subarray_sum_search test failed");
        $finish;
    end

endmodule

### files.f
rtl/core/ssum_pkg.sv
rtl/core/ssum_ctrl.sv
rtl/core/ssum_dp.sv
rtl/core/subarray_sum_search.sv
tb/testbench.sv
